// File: rtl/core/kto_pkg.sv
// package for keyed_table_oldest_evict: record table types, opcodes, fsm states
// no dependencies
`default_nettype none
package kto_pkg;
  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = 6;
  localparam int unsigned RecW = 256;

  // byte address of the table limit register
  localparam logic [1:0] RegTableLimit = 2'd0;

  typedef enum logic [2:0] {
    OP_SET = 3'd0, OP_REMOVE = 3'd1, OP_LOOK_TAG = 3'd2, OP_LOOK_KEY = 3'd3, OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_REQ, ST_SCAN_CHK, ST_OLD_REQ, ST_OLD_CHK, ST_MOVE_REQ, ST_MOVE_WR,
    ST_READ_HIT, ST_HIT_OUT, ST_WRITE, ST_DONE
  } state_t;
endpackage
`default_nettype wire

// File: rtl/core/keyed_table_oldest_evict.sv
// keyed record table: one item at a time, walked by a single compare unit
// sets run a key scan then, with the table at its limit, an oldest-stamp scan;
// lookups and removes run the key or tag scan; each entry needs a ram read and
// a compare
// a new item is taken only once the last result has been taken; in_tready is low
// while an item is at work or its result waits
// reset: synchronous active-low; count 0, seq 1, limit 32; ram contents undefined
`default_nettype none
module keyed_table_oldest_evict (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: operation[2:0], host_id[66:3], share_id[130:67], stamp[194:131],
  // tag_key[258:195], zero fill to 264
  input  wire logic [263:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: status[0], found_host[64:1], found_share[128:65], found_stamp[192:129],
  // result_tag[256:193], used_count[262:257], change_seq[326:263], zero fill to 328
  output logic      [327:0] out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [1:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic      [31:0]  cfg_prdata,
  output logic              cfg_pready
);
  localparam int unsigned IW = kto_pkg::IdxW;
  localparam int unsigned CW = kto_pkg::CntW;

  // configuration register
  logic [CW-1:0] limit_r, limit_nxt;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == kto_pkg::RegTableLimit) ?
                      {{(32-CW){1'b0}}, limit_r} : 32'd0;
  always_comb begin
    limit_nxt = limit_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == kto_pkg::RegTableLimit) begin
      limit_nxt = cfg_pwdata[CW-1:0];
    end
  end
  // effective limit saturates at the table depth
  logic [CW-1:0] eff_limit;
  assign eff_limit = (limit_r > CW'(kto_pkg::TableDepth)) ? CW'(kto_pkg::TableDepth) : limit_r;

  // captured item
  logic [2:0]  op_r;
  logic [63:0] host_r, share_r, stamp_r, tag_r;

  // control
  kto_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0]   seq_r, seq_nxt;
  logic [CW-1:0] idx_r, idx_nxt;     // scan pointer
  logic [IW-1:0] at_r, at_nxt;       // hit or oldest slot
  logic [63:0]   min_r, min_nxt;     // running oldest stamp
  logic          out_v_r, out_v_nxt;
  logic [327:0]  out_d_r, out_d_nxt;

  // record ram: {tag, stamp, share, host}
  logic                    ram_we;
  logic [IW-1:0]           ram_wa, ram_ra;
  logic [kto_pkg::RecW-1:0] ram_wd, ram_rd;
  kto_ram #(.Width(kto_pkg::RecW), .Depth(kto_pkg::TableDepth)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra), .rdata(ram_rd)
  );

  logic [63:0] rd_host, rd_share, rd_stamp, rd_tag;
  assign rd_host  = ram_rd[63:0];
  assign rd_share = ram_rd[127:64];
  assign rd_stamp = ram_rd[191:128];
  assign rd_tag   = ram_rd[255:192];

  // shared compare unit: key or tag match on the entry just read
  logic is_hit;
  assign is_hit = (op_r == kto_pkg::OP_REMOVE || op_r == kto_pkg::OP_LOOK_TAG) ?
                  (rd_tag == tag_r) : (rd_host == host_r && rd_share == share_r);

  logic          accept;
  logic [CW-1:0] last_idx;
  assign accept   = in_tvalid && in_tready;
  assign in_tready = (st_r == kto_pkg::ST_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign last_idx = cnt_r - CW'(1);

  function automatic logic [327:0] pack_out(input logic st, input logic [63:0] fh,
      input logic [63:0] fs, input logic [63:0] fst, input logic [63:0] rt,
      input logic [5:0] uc, input logic [63:0] sq);
    pack_out = {1'b0, sq, uc, rt, fst, fs, fh, st};
  endfunction

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      kto_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_tdata[2:0])
            kto_pkg::OP_SET: st_nxt = (eff_limit == '0) ? kto_pkg::ST_DONE :
                                      kto_pkg::ST_SCAN_REQ;
            kto_pkg::OP_REMOVE, kto_pkg::OP_LOOK_TAG, kto_pkg::OP_LOOK_KEY:
              st_nxt = kto_pkg::ST_SCAN_REQ;
            default: st_nxt = kto_pkg::ST_DONE;
          endcase
        end
      end
      kto_pkg::ST_SCAN_REQ:
        if (idx_r >= cnt_r) begin
          if (op_r != kto_pkg::OP_SET || cnt_r > eff_limit) st_nxt = kto_pkg::ST_DONE;
          else if (cnt_r == eff_limit) st_nxt = kto_pkg::ST_OLD_REQ;
          else st_nxt = kto_pkg::ST_WRITE;
        end else begin
          st_nxt = kto_pkg::ST_SCAN_CHK;
        end
      kto_pkg::ST_SCAN_CHK:
        if (is_hit) begin
          case (op_r)
            kto_pkg::OP_SET:    st_nxt = kto_pkg::ST_WRITE;
            kto_pkg::OP_REMOVE: st_nxt = kto_pkg::ST_MOVE_REQ;
            default:            st_nxt = kto_pkg::ST_HIT_OUT;
          endcase
        end else begin
          st_nxt = kto_pkg::ST_SCAN_REQ;
        end
      kto_pkg::ST_OLD_REQ:
        st_nxt = (idx_r >= cnt_r) ? kto_pkg::ST_MOVE_REQ : kto_pkg::ST_OLD_CHK;
      kto_pkg::ST_OLD_CHK:  st_nxt = kto_pkg::ST_OLD_REQ;
      kto_pkg::ST_MOVE_REQ: st_nxt = kto_pkg::ST_MOVE_WR;
      kto_pkg::ST_MOVE_WR:
        st_nxt = (op_r == kto_pkg::OP_SET) ? kto_pkg::ST_WRITE : kto_pkg::ST_DONE;
      kto_pkg::ST_HIT_OUT:  st_nxt = kto_pkg::ST_DONE;
      kto_pkg::ST_WRITE:    st_nxt = kto_pkg::ST_DONE;
      kto_pkg::ST_DONE:     st_nxt = kto_pkg::ST_IDLE;
      default:              st_nxt = kto_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt   = cnt_r;
    seq_nxt   = seq_r;
    idx_nxt   = idx_r;
    at_nxt    = at_r;
    min_nxt   = min_r;
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    ram_we    = 1'b0;
    ram_wa    = at_r;
    ram_wd    = {rd_tag, rd_stamp, rd_share, rd_host};
    ram_ra    = idx_r[IW-1:0];
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
    case (st_r)
      kto_pkg::ST_IDLE: begin
        idx_nxt = '0;
        // result register holds a waiting result until a new item comes in
        if (accept) begin
          // miss or refusal reports status 1 unless overwritten later
          out_d_nxt = pack_out(1'b1, '0, '0, '0, '0, '0, '0);
          if (in_tdata[2:0] > 3'(kto_pkg::OP_CLEAR)) begin
            out_d_nxt[0] = 1'b0;
          end
          if (in_tdata[2:0] == kto_pkg::OP_CLEAR) begin
            out_d_nxt[0] = 1'b0;
            cnt_nxt = '0;
            seq_nxt = 64'd1;
          end
        end
      end
      kto_pkg::ST_SCAN_CHK: begin
        at_nxt  = idx_r[IW-1:0];
        idx_nxt = idx_r + CW'(1);
        if (is_hit) begin
          idx_nxt = CW'(1);
          if (op_r == kto_pkg::OP_SET) out_d_nxt[0] = 1'b0;
          if (op_r == kto_pkg::OP_REMOVE) out_d_nxt[0] = 1'b0;
        end else if (idx_r + CW'(1) >= cnt_r) begin
          idx_nxt = idx_r + CW'(1);
        end
        // oldest scan starts from entry 0 as the running minimum
        if (!is_hit && idx_r == '0) min_nxt = rd_stamp;
        if (!is_hit) at_nxt = at_r;
      end
      kto_pkg::ST_SCAN_REQ: begin
        if (idx_r >= cnt_r && op_r == kto_pkg::OP_SET && cnt_r == eff_limit) begin
          // entry 0 stamp already latched during the key scan
          idx_nxt = CW'(1);
          at_nxt  = '0;
        end
      end
      kto_pkg::ST_OLD_CHK: begin
        if (rd_stamp < min_r) begin
          min_nxt = rd_stamp;
          at_nxt  = idx_r[IW-1:0];
        end
        idx_nxt = idx_r + CW'(1);
      end
      kto_pkg::ST_MOVE_REQ: begin
        ram_ra = last_idx[IW-1:0];
      end
      kto_pkg::ST_MOVE_WR: begin
        ram_we  = (at_r != last_idx[IW-1:0]);
        cnt_nxt = last_idx;
        seq_nxt = seq_r + 64'd1;
      end
      kto_pkg::ST_HIT_OUT: begin
        out_d_nxt = pack_out(1'b0, rd_host, rd_share, rd_stamp, rd_tag, '0, '0);
      end
      kto_pkg::ST_WRITE: begin
        ram_we = 1'b1;
        seq_nxt = seq_r + 64'd1;
        out_d_nxt[0] = 1'b0;
        if (out_d_r[0] == 1'b0) begin
          // key hit: update stamp and tag in place
          ram_wd = {tag_r, stamp_r, share_r, host_r};
          out_d_nxt[256:193] = tag_r;
        end else begin
          ram_wa  = cnt_r[IW-1:0];
          ram_wd  = {seq_r, stamp_r, share_r, host_r};
          cnt_nxt = cnt_r + CW'(1);
          out_d_nxt[256:193] = seq_r;
        end
      end
      kto_pkg::ST_DONE: begin
        out_v_nxt = 1'b1;
        out_d_nxt[262:257] = cnt_r;
        out_d_nxt[326:263] = seq_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= kto_pkg::ST_IDLE;
      limit_r <= CW'(32);
      cnt_r   <= '0;
      seq_r   <= 64'd1;
      out_v_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      limit_r <= limit_nxt;
      cnt_r   <= cnt_nxt;
      seq_r   <= seq_nxt;
      out_v_r <= out_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    at_r    <= at_nxt;
    min_r   <= min_nxt;
    out_d_r <= out_d_nxt;
    if (accept) begin
      op_r    <= in_tdata[2:0];
      host_r  <= in_tdata[66:3];
      share_r <= in_tdata[130:67];
      stamp_r <= in_tdata[194:131];
      tag_r   <= in_tdata[258:195];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(kto_pkg::TableDepth)) else $error("record count above depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != kto_pkg::ST_IDLE) |-> !in_tready) else $error("ready while busy");
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == kto_pkg::ST_DONE) |=> out_tvalid) else $error("result missing");
`endif
endmodule
`default_nettype wire

// File: rtl/core/kto_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module kto_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: bench/keyed_table_oldest_evict_test.sv
// testbench for keyed_table_oldest_evict: directed and random record-table items
// checked against a behavioral table model; depends on kto_pkg and the block rtl
module keyed_table_oldest_evict_test;

  localparam int Depth = kto_pkg::TableDepth;

  typedef struct packed {
    logic [63:0] tag_key;
    logic [63:0] stamp;
    logic [63:0] share_id;
    logic [63:0] host_id;
    logic [2:0]  operation;
  } cmd_t;

  typedef struct packed {
    logic [63:0] change_seq;
    logic [5:0]  used_count;
    logic [63:0] result_tag;
    logic [63:0] found_stamp;
    logic [63:0] found_share;
    logic [63:0] found_host;
    logic        status;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [263:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [327:0] out_tdata;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  always #2 clk = ~clk;

  keyed_table_oldest_evict DUT (.*);

  // shadow copy of the table
  logic [63:0] tbl_host [Depth];
  logic [63:0] tbl_share[Depth];
  logic [63:0] tbl_stamp[Depth];
  logic [63:0] tbl_tag  [Depth];
  int unsigned tbl_count;
  logic [63:0] seq_now;
  int unsigned limit_reg;

  reply_t pending_replies[$];
  int errors = 0;
  int items_sent = 0, replies_seen = 0;
  bit hold_off = 1'b0;    // forces the receiver into a long stall
  bit stall_mode = 1'b1;  // random receiver stalls on or off

  // key pool keeps sets hitting existing records often
  logic [63:0] key_host[8];
  logic [63:0] key_share[8];

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int find_key(logic [63:0] h, logic [63:0] s);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_host[i] == h && tbl_share[i] == s) return i;
    return -1;
  endfunction

  function automatic int find_tag(logic [63:0] t);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_tag[i] == t) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int slot);
    int last;
    last = tbl_count - 1;
    tbl_host[slot] = tbl_host[last];
    tbl_share[slot] = tbl_share[last];
    tbl_stamp[slot] = tbl_stamp[last];
    tbl_tag[slot] = tbl_tag[last];
    tbl_count = last;
  endfunction

  // apply one item to the shadow table and return the reply it should produce
  function automatic reply_t apply_table_op(cmd_t c);
    reply_t r;
    int at, lim, oldest;
    r = '0;
    lim = (limit_reg < Depth) ? limit_reg : Depth;
    case (c.operation)
      kto_pkg::OP_SET: begin
        at = find_key(c.host_id, c.share_id);
        if (lim == 0) begin
          r.status = 1'b1;
        end else if (at >= 0) begin
          tbl_stamp[at] = c.stamp;
          tbl_tag[at] = c.tag_key;
          seq_now++;
          r.result_tag = c.tag_key;
        end else if (tbl_count > lim) begin
          r.status = 1'b1;
        end else begin
          if (tbl_count == lim) begin
            // evict the true minimum stamp, lowest index on a tie
            oldest = 0;
            for (int i = 1; i < tbl_count; i++)
              if (tbl_stamp[i] < tbl_stamp[oldest]) oldest = i;
            drop_slot(oldest);
            seq_now++;
          end
          tbl_host[tbl_count] = c.host_id;
          tbl_share[tbl_count] = c.share_id;
          tbl_stamp[tbl_count] = c.stamp;
          tbl_tag[tbl_count] = seq_now;
          r.result_tag = seq_now;
          tbl_count++;
          seq_now++;
        end
      end
      kto_pkg::OP_REMOVE: begin
        at = find_tag(c.tag_key);
        if (at >= 0) begin
          drop_slot(at);
          seq_now++;
        end else begin
          r.status = 1'b1;
        end
      end
      kto_pkg::OP_LOOK_TAG, kto_pkg::OP_LOOK_KEY: begin
        at = (c.operation == kto_pkg::OP_LOOK_TAG) ? find_tag(c.tag_key)
                                                   : find_key(c.host_id, c.share_id);
        if (at >= 0) begin
          r.found_host = tbl_host[at];
          r.found_share = tbl_share[at];
          r.found_stamp = tbl_stamp[at];
          r.result_tag = tbl_tag[at];
        end else begin
          r.status = 1'b1;
        end
      end
      kto_pkg::OP_CLEAR: begin
        tbl_count = 0;
        seq_now = 64'd1;
      end
      default: ;  // codes five to seven are ignored
    endcase
    r.used_count = tbl_count[5:0];
    r.change_seq = seq_now;
    return r;
  endfunction

  // send one item, with a random gap first in bursty mode; valid stays up
  // until the next item or a drain, the block is busy right after an accept
  task automatic send_item(cmd_t c, bit bursty = 1'b1);
    if (bursty && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tdata <= {5'd0, c};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_replies.push_back(apply_table_op(c));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    // let a set finish its scans before touching the register
    repeat (4 * Depth + 16) @(negedge clk);
  endtask

  task automatic write_limit(int unsigned v);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= kto_pkg::RegTableLimit; cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    limit_reg = v & 63;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  function automatic cmd_t make_cmd(kto_pkg::op_t op, logic [63:0] h, logic [63:0] s,
                                    logic [63:0] st, logic [63:0] t);
    cmd_t c;
    c.operation = op; c.host_id = h; c.share_id = s; c.stamp = st; c.tag_key = t;
    return c;
  endfunction

  // tags near the live ones so removes and lookups hit
  function automatic logic [63:0] pick_tag();
    if (tbl_count != 0 && $urandom_range(0, 3) != 0)
      return tbl_tag[$urandom_range(0, tbl_count - 1)];
    return ($urandom_range(0, 1)) ? seq_now - $urandom_range(0, 40) : rand64();
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int k, sel;
    k = $urandom_range(0, 7);
    c.host_id = key_host[k];
    c.share_id = key_share[k];
    if ($urandom_range(0, 4) == 0) begin
      c.host_id = rand64();
      c.share_id = rand64();
    end
    c.stamp = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 50));
    c.tag_key = pick_tag();
    sel = $urandom_range(0, 99);
    if (sel < 45) c.operation = kto_pkg::OP_SET;
    else if (sel < 60) c.operation = kto_pkg::OP_REMOVE;
    else if (sel < 75) c.operation = kto_pkg::OP_LOOK_TAG;
    else if (sel < 92) c.operation = kto_pkg::OP_LOOK_KEY;
    else if (sel < 96) c.operation = kto_pkg::OP_CLEAR;
    else c.operation = 3'($urandom_range(5, 7));
    return c;
  endfunction

  // ---------------------------------------------------------------- tests

  // field extremes, every operation and the odd codes
  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    send_item(make_cmd(kto_pkg::OP_LOOK_TAG, 0, 0, 0, 0));    // miss on empty table
    send_item(make_cmd(kto_pkg::OP_REMOVE, 0, 0, 0, 64'd1));  // remove miss
    send_item(make_cmd(kto_pkg::OP_SET, 0, 0, 0, 0));
    send_item(make_cmd(kto_pkg::OP_SET, ones, ones, ones, ones));
    send_item(make_cmd(kto_pkg::OP_SET, ones, ones, 64'd5,
                       64'hA5A5_5A5A_0F0F_F0F0));             // update
    send_item(make_cmd(kto_pkg::OP_LOOK_KEY, ones, ones, 0, 0));
    send_item(make_cmd(kto_pkg::OP_LOOK_TAG, 0, 0, 0, 64'hA5A5_5A5A_0F0F_F0F0));
    send_item(make_cmd(kto_pkg::OP_LOOK_KEY, ones, 0, 0, 0)); // partial key miss
    send_item(make_cmd(kto_pkg::op_t'(3'd5), ones, ones, ones, ones));
    send_item(make_cmd(kto_pkg::op_t'(3'd7), 0, 0, 0, 0));
    send_item(make_cmd(kto_pkg::OP_REMOVE, 0, 0, 0, 64'd1));  // remove first record
    send_item(make_cmd(kto_pkg::OP_LOOK_KEY, 0, 0, 0, 0));
    send_item(make_cmd(kto_pkg::OP_CLEAR, 0, 0, 0, 0));
    send_item(make_cmd(kto_pkg::OP_SET, 64'h1, 64'h2, 64'h3, 0));
    send_item(make_cmd(kto_pkg::OP_LOOK_TAG, 0, 0, 0, 64'd1));
    wait_drained();
  endtask

  // fill past the limit so eviction of the smallest stamp runs, ties included
  task automatic test_eviction(int unsigned lim, int n);
    write_limit(lim);
    send_item(make_cmd(kto_pkg::OP_CLEAR, 0, 0, 0, 0));
    for (int i = 0; i < n; i++)
      send_item(make_cmd(kto_pkg::OP_SET, rand64(), 64'(i), 64'($urandom_range(0, 6)), 0));
    for (int i = 0; i < 4; i++)
      send_item(make_cmd(kto_pkg::OP_LOOK_TAG, 0, 0, 0, pick_tag()));
    wait_drained();
  endtask

  // zero limit refuses sets; a lowered limit still lets matching keys update
  task automatic test_limits();
    write_limit(0);
    send_item(make_cmd(kto_pkg::OP_SET, 64'd9, 64'd9, 64'd9, 64'd9));
    send_item(make_cmd(kto_pkg::OP_LOOK_KEY, 64'd9, 64'd9, 0, 0));
    wait_drained();
    write_limit(2);
    for (int i = 0; i < 3; i++)
      send_item(make_cmd(kto_pkg::OP_SET, key_host[i], key_share[i], 64'(i), 0));
    wait_drained();
    write_limit(63);  // saturates at the table depth
    send_item(make_cmd(kto_pkg::OP_CLEAR, 0, 0, 0, 0));
    for (int i = 0; i < 6; i++)
      send_item(make_cmd(kto_pkg::OP_SET, key_host[i], key_share[i], 64'(i), 0));
    wait_drained();
    write_limit(3);  // now below the count
    send_item(make_cmd(kto_pkg::OP_SET, key_host[1], key_share[1], 64'd77, 64'd123));
    send_item(make_cmd(kto_pkg::OP_SET, rand64(), rand64(), 64'd1, 0));
    send_item(make_cmd(kto_pkg::OP_REMOVE, 0, 0, 0, 64'd123));
    wait_drained();
  endtask

  // random traffic across several limits
  task automatic test_random(int n, int unsigned lim);
    write_limit(lim);
    for (int i = 0; i < n; i++) send_item(random_cmd());
    wait_drained();
  endtask

  // receiver holds off a long time while the sender keeps offering items
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_item(random_cmd(), 1'b0);
    while (hold_off) @(negedge clk);
    wait_drained();
  endtask

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (!stall_mode) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 9) > 2);
  end

  // releases the long stall after a count of its own
  initial begin
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        held++;
        if (held >= 1500) begin
          held = 0;
          hold_off = 1'b0;
        end
      end
    end
  end

  // compare each accepted reply with the oldest expectation
  always @(posedge clk) begin
    reply_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(reply_t)-1:0];
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply %h", $time, got);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status)
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        if (got.found_host !== want.found_host)
          $display("%0t: found_host exp %h got %h", $time, want.found_host, got.found_host);
        if (got.found_share !== want.found_share)
          $display("%0t: found_share exp %h got %h", $time, want.found_share,
                   got.found_share);
        if (got.found_stamp !== want.found_stamp)
          $display("%0t: found_stamp exp %h got %h", $time, want.found_stamp,
                   got.found_stamp);
        if (got.result_tag !== want.result_tag)
          $display("%0t: result_tag exp %h got %h", $time, want.result_tag, got.result_tag);
        if (got.used_count !== want.used_count)
          $display("%0t: used_count exp %0d got %0d", $time, want.used_count,
                   got.used_count);
        if (got.change_seq !== want.change_seq)
          $display("%0t: change_seq exp %h got %h", $time, want.change_seq, got.change_seq);
        if (got !== want) errors++;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    tbl_count = 0;
    seq_now = 64'd1;
    limit_reg = 32;
    for (int i = 0; i < 8; i++) begin
      key_host[i] = rand64();
      key_share[i] = rand64();
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_eviction(32, 40);
    test_eviction(1, 5);
    test_limits();
    test_backpressure();
    test_random(500, 32);
    test_random(300, 4);
    stall_mode = 1'b0;  // a stretch with a ready receiver
    test_random(300, 8);
    stall_mode = 1'b1;
    test_random(400, 32);
    test_random(100, 1);
    $display("covered %0d items and %0d replies: set, evict, remove, lookups, clear,",
             items_sent, replies_seen);
    $display("limits 0 to 63, lowered limit, long receiver hold-off");
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
